// File: hdl/xaut_pkg.sv
// Shared types, result kind codes and entity tables for the attribute tokenizer.
package xaut_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned ENT_COUNT  = 7;
    localparam int unsigned ENT_MAXLEN = 5;
    localparam int unsigned ENT_POS_W  = 3;
    localparam int unsigned ENT_IDX_W  = 3;

    localparam logic [KIND_W-1:0] KIND_NAME     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NAME_END = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VALUE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ATTR_END = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST_END = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              restart;
    } item_t;

    // entity text after the ampersand, first byte in the top bits, zero padded
    function automatic logic [ENT_MAXLEN*BYTE_W-1:0] ent_text(input logic [ENT_IDX_W-1:0] idx);
        logic [ENT_MAXLEN*BYTE_W-1:0] t;
        unique case (idx)
            3'd0:    t = {"#10;", 8'h00};
            3'd1:    t = {"#13;", 8'h00};
            3'd2:    t = {"#9;", 16'h0000};
            3'd3:    t = "quot;";
            3'd4:    t = {"lt;", 16'h0000};
            3'd5:    t = {"gt;", 16'h0000};
            3'd6:    t = {"amp;", 8'h00};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [BYTE_W-1:0] ent_char(input logic [ENT_IDX_W-1:0] idx,
                                                   input logic [ENT_POS_W-1:0] pos);
        logic [ENT_MAXLEN*BYTE_W-1:0] t;
        logic [BYTE_W-1:0]            c;
        t = ent_text(idx);
        unique case (pos)
            3'd0:    c = t[39:32];
            3'd1:    c = t[31:24];
            3'd2:    c = t[23:16];
            3'd3:    c = t[15:8];
            3'd4:    c = t[7:0];
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [ENT_POS_W-1:0] ent_len(input logic [ENT_IDX_W-1:0] idx);
        logic [ENT_POS_W-1:0] n;
        unique case (idx)
            3'd0, 3'd1, 3'd6: n = 3'd4;
            3'd3:             n = 3'd5;
            default:          n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] ent_byte(input logic [ENT_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            3'd0:    b = 8'h0A;
            3'd1:    b = 8'h0D;
            3'd2:    b = 8'h09;
            3'd3:    b = 8'h22;
            3'd4:    b = 8'h3C;
            3'd5:    b = 8'h3E;
            3'd6:    b = 8'h26;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/xaut_in_stage.sv
// Input register: captures one item per cycle from the slave stream while s_ready is high.
module xaut_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  xaut_pkg::item_t s_item,
    output logic            q_valid,
    input  logic            q_take,
    output xaut_pkg::item_t q_item
);

    logic            valid_reg;
    logic            valid_next;
    xaut_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || q_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !q_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// File: hdl/xaut_parser.sv
// Parser state, entity matcher and registered result item.
module xaut_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_take,
    input  xaut_pkg::item_t               q_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [xaut_pkg::BYTE_W-1:0]   m_byte,
    output logic [xaut_pkg::KIND_W-1:0]   m_kind
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_EQ     = 3'd2;
    localparam logic [2:0] PH_VALUE  = 3'd3;
    localparam logic [2:0] PH_ENTITY = 3'd4;

    localparam logic [xaut_pkg::ENT_COUNT-1:0] ENT_ALL = '1;

    logic [2:0]                         phase_reg, phase_next;
    logic [xaut_pkg::ENT_POS_W-1:0]     pos_reg, pos_next;
    logic [xaut_pkg::ENT_COUNT-1:0]     cand_reg, cand_next;
    logic                               stopped_reg, stopped_next;
    logic                               out_valid_reg, out_valid_next;
    logic [xaut_pkg::BYTE_W-1:0]        out_byte_reg, out_byte_next;
    logic [xaut_pkg::KIND_W-1:0]        out_kind_reg, out_kind_next;

    logic [2:0]                         ph;
    logic [xaut_pkg::ENT_POS_W-1:0]     pos;
    logic [xaut_pkg::ENT_COUNT-1:0]     cand;
    logic                               stp;
    logic [xaut_pkg::BYTE_W-1:0]        c;
    logic                               is_name, is_space;
    logic [xaut_pkg::ENT_COUNT-1:0]     live;
    logic                               done;
    logic [xaut_pkg::BYTE_W-1:0]        done_byte;
    logic                               emit;
    logic [xaut_pkg::BYTE_W-1:0]        emit_byte;
    logic [xaut_pkg::KIND_W-1:0]        emit_kind;

    assign q_take = q_valid && (!out_valid_reg || m_ready);

    always_comb begin
        ph   = q_item.restart ? PH_START : phase_reg;
        pos  = q_item.restart ? '0 : pos_reg;
        cand = q_item.restart ? ENT_ALL : cand_reg;
        stp  = q_item.restart ? 1'b0 : stopped_reg;
        c    = q_item.in_byte;

        is_name  = (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
        is_space = c == 8'h20 || c == 8'h09 || c == 8'h0A;

        for (int i = 0; i < xaut_pkg::ENT_COUNT; i++) begin
            live[i] = cand[i] && (pos < xaut_pkg::ent_len(xaut_pkg::ENT_IDX_W'(i)))
                      && (xaut_pkg::ent_char(xaut_pkg::ENT_IDX_W'(i), pos) == c);
        end
        done      = 1'b0;
        done_byte = '0;
        for (int i = xaut_pkg::ENT_COUNT - 1; i >= 0; i--) begin
            if (live[i] && (pos + 3'd1 == xaut_pkg::ent_len(xaut_pkg::ENT_IDX_W'(i)))) begin
                done      = 1'b1;
                done_byte = xaut_pkg::ent_byte(xaut_pkg::ENT_IDX_W'(i));
            end
        end

        phase_next   = ph;
        pos_next     = pos;
        cand_next    = cand;
        stopped_next = stp;
        emit         = 1'b0;
        emit_byte    = '0;
        emit_kind    = xaut_pkg::KIND_ERROR;

        if (!stp) begin
            unique case (ph)
                PH_START: begin
                    priority if (is_space) begin
                    end else if (c == 8'h00) begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                        emit_kind    = xaut_pkg::KIND_LIST_END;
                    end else if (c == 8'h3D) begin
                        phase_next = PH_EQ;
                    end else if (is_name) begin
                        phase_next = PH_NAME;
                        emit       = 1'b1;
                        emit_byte  = c;
                        emit_kind  = xaut_pkg::KIND_NAME;
                    end else begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                    end
                end
                PH_NAME: begin
                    priority if (is_name) begin
                        emit      = 1'b1;
                        emit_byte = c;
                        emit_kind = xaut_pkg::KIND_NAME;
                    end else if (c == 8'h3D) begin
                        phase_next = PH_EQ;
                    end else begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                    end
                end
                PH_EQ: begin
                    if (c == 8'h22) begin
                        phase_next = PH_VALUE;
                        emit       = 1'b1;
                        emit_kind  = xaut_pkg::KIND_NAME_END;
                    end else begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                    end
                end
                PH_VALUE: begin
                    priority if (c == 8'h22) begin
                        phase_next = PH_START;
                        emit       = 1'b1;
                        emit_kind  = xaut_pkg::KIND_ATTR_END;
                    end else if (c == 8'h00) begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                    end else if (c == 8'h26) begin
                        phase_next = PH_ENTITY;
                        pos_next   = '0;
                        cand_next  = ENT_ALL;
                    end else begin
                        emit      = 1'b1;
                        emit_byte = c;
                        emit_kind = xaut_pkg::KIND_VALUE;
                    end
                end
                PH_ENTITY: begin
                    priority if (pos >= xaut_pkg::ENT_POS_W'(xaut_pkg::ENT_MAXLEN)
                                 || live == '0 || c == 8'h00) begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                    end else if (done) begin
                        phase_next = PH_VALUE;
                        pos_next   = '0;
                        cand_next  = ENT_ALL;
                        emit       = 1'b1;
                        emit_byte  = done_byte;
                        emit_kind  = xaut_pkg::KIND_VALUE;
                    end else begin
                        cand_next = live;
                        pos_next  = pos + 3'd1;
                    end
                end
                default: begin
                    stopped_next = 1'b1;
                    emit         = 1'b1;
                end
            endcase
        end

        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        if (q_take && emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_kind_next  = emit_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            pos_reg       <= '0;
            cand_reg      <= ENT_ALL;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_take) begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                cand_reg    <= cand_next;
                stopped_reg <= stopped_next;
            end
            out_valid_reg <= out_valid_next;
        end
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_valid = out_valid_reg;
    assign m_byte  = out_byte_reg;
    assign m_kind  = out_kind_reg;

endmodule

// File: hdl/xml_attribute_unescape_tokenizer.sv
// Top level of the XML attribute tokenizer with entity unescaping.
// Takes one attribute-list byte per cycle and gives at most one token per byte. A token is
// offered from the result register once its byte has passed the input register. A byte can
// be accepted every cycle while m_axis_tready is high. While a finished token waits, the
// input register takes at most one more byte and then holds. The rate is set by the parser
// step between the input register and the result register (state update plus a seven-way
// entity match). Bytes that give no token (whitespace, '=', entity bytes before ';',
// anything once stopped) vanish. Set tuser to restart the parser before that byte.
module xml_attribute_unescape_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0] s_axis_tuser,   // [0] restart
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser    // [2:0] kind
);

    xaut_pkg::item_t s_item;
    xaut_pkg::item_t q_item;
    logic            q_valid;
    logic            q_take;

    assign s_item.in_byte = s_axis_tdata;
    assign s_item.restart = s_axis_tuser[0];

    xaut_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    xaut_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_byte  (m_axis_tdata),
        .m_kind  (m_axis_tuser)
    );

endmodule
